// ----- hw/rtl/rtmp_chunk_stream_parser_macros.svh -----
// Assertion macros shared by the chunk stream parser modules
`ifndef RTMP_CHUNK_STREAM_PARSER_MACROS_SVH
`define RTMP_CHUNK_STREAM_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define RCSP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define RCSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RCSP_ASSERT_SAME(label, ante, cons, msg)
`define RCSP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/rcsp_pkg.sv -----
// Types and constants shared by the chunk stream parser modules
package rcsp_pkg;

   localparam int CHUNK_COUNT_WIDTH = 17;
   localparam int CHUNK_SIZE_WIDTH  = 17;
   localparam int FILL_CMP_WIDTH    =
      (CHUNK_COUNT_WIDTH > CHUNK_SIZE_WIDTH) ? CHUNK_COUNT_WIDTH : CHUNK_SIZE_WIDTH;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);

   localparam logic [CHUNK_SIZE_WIDTH-1:0] CHUNK_SIZE_RESET = 17'd128;

   localparam logic [1:0] ST_HEADER  = 2'd0;
   localparam logic [1:0] ST_PAYLOAD = 2'd1;
   localparam logic [1:0] ST_LAST    = 2'd2;
   localparam logic [1:0] ST_ERROR   = 2'd3;

   localparam logic [1:0]  FMT_TS_ONLY   = 2'd2;
   localparam logic [1:0]  FMT_NO_SID    = 2'd1;
   localparam logic [1:0]  FMT_CONTINUE  = 2'd3;
   localparam logic [5:0]  ID_TWO_BYTE   = 6'd0;
   localparam logic [5:0]  ID_THREE_BYTE = 6'd1;
   localparam logic [16:0] ID_OFFSET     = 17'd64;
   localparam logic [31:0] TS_EXTENDED   = 32'h00FF_FFFF;

   typedef logic [CHUNK_COUNT_WIDTH-1:0] fill_type;
   typedef logic [FILL_CMP_WIDTH-1:0]    fill_cmp_type;
   typedef logic [CHUNK_SIZE_WIDTH-1:0]  chunk_size_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  payload_byte;
      logic [1:0]  chunk_fmt;
      logic [16:0] chunk_stream;
      logic [31:0] msg_timestamp;
      logic [23:0] msg_length;
      logic [7:0]  msg_type;
      logic [31:0] msg_stream;
      logic        chunk_end;
   } rsp_type;

endpackage

// ----- hw/rtl/rtmp_chunk_stream_parser.sv -----
// Top level of the chunk stream parser: chunk size register, queue and parser
//
// Takes one raw chunk stream byte per request beat and returns one response beat per byte:
// a header, payload, last-of-message or error status with the decoded basic and message
// header fields. Sustained rate is one byte per clock while the response side is not
// stalled; each byte is registered in the four-entry input queue, then in the response
// register of the single-step header parser that updates all context registers per byte.
// The request side stalls only when the queue is full because the response side is stalled.
// The chunk size register is written through the csr channel, which is always ready; a size
// of zero acts as one.
module rtmp_chunk_stream_parser import rcsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_payload_byte,
   output logic [1:0]  rsp_chunk_fmt,
   output logic [16:0] rsp_chunk_stream,
   output logic [31:0] rsp_msg_timestamp,
   output logic [23:0] rsp_msg_length,
   output logic [7:0]  rsp_msg_type,
   output logic [31:0] rsp_msg_stream,
   output logic        rsp_chunk_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_chunk_size
);

   chunk_size_type chunk_size_ff;
   logic           q_valid;
   logic [7:0]     q_byte;
   logic           q_pop;
   rsp_type        rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= CHUNK_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         chunk_size_ff <= csr_chunk_size;
      end
   end

   rcsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .q_valid     (q_valid),
      .q_byte      (q_byte),
      .q_pop       (q_pop)
   );

   rcsp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .chunk_size (chunk_size_ff),
      .q_valid    (q_valid),
      .q_byte     (q_byte),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   assign rsp_status        = rsp.status;
   assign rsp_payload_byte  = rsp.payload_byte;
   assign rsp_chunk_fmt     = rsp.chunk_fmt;
   assign rsp_chunk_stream  = rsp.chunk_stream;
   assign rsp_msg_timestamp = rsp.msg_timestamp;
   assign rsp_msg_length    = rsp.msg_length;
   assign rsp_msg_type      = rsp.msg_type;
   assign rsp_msg_stream    = rsp.msg_stream;
   assign rsp_chunk_end     = rsp.chunk_end;

endmodule

// ----- hw/rtl/rcsp_queue.sv -----
// Input byte queue: accepts request beats and holds them for the parser
`include "rtmp_chunk_stream_parser_macros.svh"
module rcsp_queue import rcsp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       q_valid,
   output logic [7:0] q_byte,
   input  logic       q_pop
);

   logic [7:0]                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_WIDTH:0]   count_ff, count_in;
   logic                       push;
   logic                       full;

   assign full      = (count_ff == (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH));
   assign req_stall = full;
   assign push      = req_valid && !full;
   assign q_valid   = (count_ff != '0);
   assign q_byte    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR_WIDTH+1)'(push) - (QUEUE_PTR_WIDTH+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_in_byte;
      end
   end

   `RCSP_ASSERT_SAME(a_pop_nonempty, q_pop, count_ff != '0, "pop from empty queue")
   `RCSP_ASSERT_NEXT(a_count_track, push && !q_pop, count_ff == $past(count_ff) + 1'b1,
                     "queue count lost a beat")

endmodule

// ----- hw/rtl/rcsp_parser.sv -----
// Chunk header parser and response register
`include "rtmp_chunk_stream_parser_macros.svh"
module rcsp_parser import rcsp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  chunk_size_type chunk_size,
   input  logic           q_valid,
   input  logic [7:0]     q_byte,
   output logic           q_pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp
);

   localparam logic [4:0] PH_BASIC = 5'd0;
   localparam logic [4:0] PH_ID_LO = 5'd1;
   localparam logic [4:0] PH_ID_HI = 5'd2;
   localparam logic [4:0] PH_TS0   = 5'd3;
   localparam logic [4:0] PH_TS1   = 5'd4;
   localparam logic [4:0] PH_TS2   = 5'd5;
   localparam logic [4:0] PH_LEN0  = 5'd6;
   localparam logic [4:0] PH_LEN1  = 5'd7;
   localparam logic [4:0] PH_LEN2  = 5'd8;
   localparam logic [4:0] PH_TYPE  = 5'd9;
   localparam logic [4:0] PH_SID0  = 5'd10;
   localparam logic [4:0] PH_SID1  = 5'd11;
   localparam logic [4:0] PH_SID2  = 5'd12;
   localparam logic [4:0] PH_SID3  = 5'd13;
   localparam logic [4:0] PH_EXT0  = 5'd14;
   localparam logic [4:0] PH_EXT1  = 5'd15;
   localparam logic [4:0] PH_EXT2  = 5'd16;
   localparam logic [4:0] PH_EXT3  = 5'd17;
   localparam logic [4:0] PH_DATA  = 5'd18;

   logic [4:0]  phase_ff, phase_in;
   logic [1:0]  fmt_ff, fmt_in;
   logic [16:0] chan_ff, chan_in;
   logic        wide_ff, wide_in;
   logic [31:0] time_ff, time_in;
   logic [23:0] len_ff, len_in;
   logic [7:0]  kind_ff, kind_in;
   logic [31:0] sid_ff, sid_in;
   logic        ext_ff, ext_in;
   logic [23:0] rcv_ff, rcv_in;
   fill_type    fill_ff, fill_in;
   logic        fresh_ff, fresh_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic           basic_done, fields_done, header_done, do_clear;
   logic [1:0]     status;
   logic [7:0]     pay;
   logic           cend;
   fill_type       next_fill;
   chunk_size_type limit;
   logic [7:0]     b;

   assign b         = q_byte;
   assign q_pop     = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign limit     = (chunk_size == '0) ? chunk_size_type'(1) : chunk_size;
   assign next_fill = fill_ff + 1'b1;

   always_comb begin
      phase_in    = phase_ff;
      fmt_in      = fmt_ff;
      chan_in     = chan_ff;
      wide_in     = wide_ff;
      time_in     = time_ff;
      len_in      = len_ff;
      kind_in     = kind_ff;
      sid_in      = sid_ff;
      ext_in      = ext_ff;
      rcv_in      = rcv_ff;
      fill_in     = fill_ff;
      fresh_in    = fresh_ff;
      status      = ST_HEADER;
      pay         = '0;
      cend        = 1'b0;
      do_clear    = 1'b0;
      basic_done  = 1'b0;
      fields_done = 1'b0;
      header_done = 1'b0;

      unique case (phase_ff)
         PH_ID_LO: begin
            if (wide_ff) begin
               chan_in  = {9'd0, b};
               phase_in = PH_ID_HI;
            end else begin
               chan_in    = {9'd0, b} + ID_OFFSET;
               basic_done = 1'b1;
            end
         end
         PH_ID_HI: begin
            chan_in    = {1'b0, b, chan_ff[7:0]} + ID_OFFSET;
            basic_done = 1'b1;
         end
         PH_TS0: begin
            time_in  = {8'd0, b, 16'd0};
            phase_in = PH_TS1;
         end
         PH_TS1: begin
            time_in  = time_ff | {16'd0, b, 8'd0};
            phase_in = PH_TS2;
         end
         PH_TS2: begin
            time_in = time_ff | {24'd0, b};
            ext_in  = (time_in == TS_EXTENDED);
            if (fmt_ff == FMT_TS_ONLY) begin
               fields_done = 1'b1;
            end else begin
               phase_in = PH_LEN0;
            end
         end
         PH_LEN0: begin
            len_in   = {b, 16'd0};
            phase_in = PH_LEN1;
         end
         PH_LEN1: begin
            len_in   = len_ff | {8'd0, b, 8'd0};
            phase_in = PH_LEN2;
         end
         PH_LEN2: begin
            len_in   = len_ff | {16'd0, b};
            phase_in = PH_TYPE;
         end
         PH_TYPE: begin
            kind_in = b;
            if (fmt_ff == FMT_NO_SID) begin
               fields_done = 1'b1;
            end else begin
               phase_in = PH_SID0;
            end
         end
         PH_SID0: begin
            sid_in   = {24'd0, b};
            phase_in = PH_SID1;
         end
         PH_SID1: begin
            sid_in   = sid_ff | {16'd0, b, 8'd0};
            phase_in = PH_SID2;
         end
         PH_SID2: begin
            sid_in   = sid_ff | {8'd0, b, 16'd0};
            phase_in = PH_SID3;
         end
         PH_SID3: begin
            sid_in      = sid_ff | {b, 24'd0};
            fields_done = 1'b1;
         end
         PH_EXT0: begin
            time_in  = {b, 24'd0};
            phase_in = PH_EXT1;
         end
         PH_EXT1: begin
            time_in  = time_ff | {8'd0, b, 16'd0};
            phase_in = PH_EXT2;
         end
         PH_EXT2: begin
            time_in  = time_ff | {16'd0, b, 8'd0};
            phase_in = PH_EXT3;
         end
         PH_EXT3: begin
            time_in     = time_ff | {24'd0, b};
            header_done = 1'b1;
         end
         PH_DATA: begin
            pay    = b;
            rcv_in = rcv_ff + 1'b1;
            if (fill_cmp_type'(next_fill) == fill_cmp_type'(limit) || next_fill == '1) begin
               cend     = 1'b1;
               fill_in  = '0;
               phase_in = PH_BASIC;
            end else begin
               fill_in = next_fill;
            end
            if (rcv_in >= len_ff) begin
               status   = ST_LAST;
               do_clear = 1'b1;
            end else begin
               status = ST_PAYLOAD;
            end
         end
         default: begin
            fmt_in  = b[7:6];
            chan_in = {11'd0, b[5:0]};
            if (b[5:0] == ID_TWO_BYTE) begin
               wide_in  = 1'b0;
               phase_in = PH_ID_LO;
            end else if (b[5:0] == ID_THREE_BYTE) begin
               wide_in  = 1'b1;
               phase_in = PH_ID_LO;
            end else begin
               basic_done = 1'b1;
            end
         end
      endcase

      if (basic_done) begin
         if (fmt_in == FMT_CONTINUE) begin
            if (fresh_ff) begin
               phase_in = PH_BASIC;
               status   = ST_ERROR;
            end else begin
               fields_done = 1'b1;
            end
         end else begin
            phase_in = PH_TS0;
         end
      end

      if (fields_done) begin
         if (ext_in) begin
            phase_in = PH_EXT0;
         end else begin
            header_done = 1'b1;
         end
      end

      if (header_done) begin
         fresh_in = 1'b0;
         if (len_in <= rcv_in) begin
            do_clear = 1'b1;
            status   = ST_LAST;
         end else begin
            phase_in = PH_DATA;
         end
      end

      rsp_in.status        = status;
      rsp_in.payload_byte  = pay;
      rsp_in.chunk_fmt     = fmt_in;
      rsp_in.chunk_stream  = chan_in;
      rsp_in.msg_timestamp = time_in;
      rsp_in.msg_length    = len_in;
      rsp_in.msg_type      = kind_in;
      rsp_in.msg_stream    = sid_in;
      rsp_in.chunk_end     = cend;
   end

   always_ff @(posedge clock) begin
      if (reset || (q_pop && do_clear)) begin
         phase_ff <= PH_BASIC;
         fmt_ff   <= '0;
         chan_ff  <= '0;
         wide_ff  <= 1'b0;
         time_ff  <= '0;
         len_ff   <= '0;
         kind_ff  <= '0;
         sid_ff   <= '0;
         ext_ff   <= 1'b0;
         rcv_ff   <= '0;
         fill_ff  <= '0;
         fresh_ff <= 1'b1;
      end else if (q_pop) begin
         phase_ff <= phase_in;
         fmt_ff   <= fmt_in;
         chan_ff  <= chan_in;
         wide_ff  <= wide_in;
         time_ff  <= time_in;
         len_ff   <= len_in;
         kind_ff  <= kind_in;
         sid_ff   <= sid_in;
         ext_ff   <= ext_in;
         rcv_ff   <= rcv_in;
         fill_ff  <= fill_in;
         fresh_ff <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   `RCSP_ASSERT_SAME(a_error_fmt, rsp_valid_ff && rsp_ff.status == ST_ERROR,
                     rsp_ff.chunk_fmt == FMT_CONTINUE, "error beat without format 3")
   `RCSP_ASSERT_SAME(a_end_on_data, rsp_valid_ff && rsp_ff.chunk_end,
                     rsp_ff.status == ST_PAYLOAD || rsp_ff.status == ST_LAST,
                     "chunk end on a header beat")
   `RCSP_ASSERT_NEXT(a_clear_ctx, q_pop && do_clear,
                     phase_ff == PH_BASIC && fresh_ff && rcv_ff == '0,
                     "context not cleared at message end")

endmodule

// ----- tb/tb_rtmp_chunk_stream_parser.sv -----
// Self-checking testbench for the RTMP chunk stream parser: byte-level predictor and scoreboard
`timescale 1ns / 1ps

module tb_rtmp_chunk_stream_parser import rcsp_pkg::*; ();

   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         HOLD_CYCLES    = 80;
   localparam int         MAX_REPORTS    = 50;
   localparam logic [1:0] FMT_FULL       = 2'd0;

   typedef enum logic [4:0] {
      AT_BASIC, AT_ID_LO, AT_ID_HI,
      AT_TS0, AT_TS1, AT_TS2,
      AT_LEN0, AT_LEN1, AT_LEN2, AT_TYPE,
      AT_SID0, AT_SID1, AT_SID2, AT_SID3,
      AT_EXT0, AT_EXT1, AT_EXT2, AT_EXT3,
      AT_DATA
   } hdr_step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_payload_byte;
   logic [1:0]  rsp_chunk_fmt;
   logic [16:0] rsp_chunk_stream;
   logic [31:0] rsp_msg_timestamp;
   logic [23:0] rsp_msg_length;
   logic [7:0]  rsp_msg_type;
   logic [31:0] rsp_msg_stream;
   logic        rsp_chunk_end;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [16:0] csr_chunk_size = 17'd0;

   rtmp_chunk_stream_parser u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_chunk_fmt     (rsp_chunk_fmt),
      .rsp_chunk_stream  (rsp_chunk_stream),
      .rsp_msg_timestamp (rsp_msg_timestamp),
      .rsp_msg_length    (rsp_msg_length),
      .rsp_msg_type      (rsp_msg_type),
      .rsp_msg_stream    (rsp_msg_stream),
      .rsp_chunk_end     (rsp_chunk_end),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_chunk_size    (csr_chunk_size)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // parser context mirror
   hdr_step_type   hdr_step;
   logic [1:0]     cur_fmt;
   logic [16:0]    cur_csid;
   logic           wide_csid;
   logic [31:0]    cur_ts;
   logic [23:0]    cur_len;
   logic [7:0]     cur_type;
   logic [31:0]    cur_msid;
   logic           ts_extended;
   logic [23:0]    payload_seen;
   fill_type       chunk_fill;
   logic           msg_fresh;
   chunk_size_type chunk_size;
   logic           msg_done;

   rsp_type expected_beats[$];
   int      mismatch_count = 0;
   int      send_idle_pct = 32;
   int      recv_idle_pct = 76;
   int      hold_requests = 0;
   int      hold_served = 0;
   int      hold_left = 0;
   int      quiet_cycles = 0;

   function automatic void clear_msg_context();
      hdr_step     = AT_BASIC;
      cur_fmt      = 2'd0;
      cur_csid     = 17'd0;
      wide_csid    = 1'b0;
      cur_ts       = 32'd0;
      cur_len      = 24'd0;
      cur_type     = 8'd0;
      cur_msid     = 32'd0;
      ts_extended  = 1'b0;
      payload_seen = 24'd0;
      chunk_fill   = '0;
      msg_fresh    = 1'b1;
   endfunction

   function automatic logic [1:0] end_of_header();
      msg_fresh = 1'b0;
      if (cur_len <= payload_seen) begin
         msg_done = 1'b1;
         return ST_LAST;
      end
      hdr_step = AT_DATA;
      return ST_HEADER;
   endfunction

   function automatic logic [1:0] end_of_fields();
      if (ts_extended) begin
         hdr_step = AT_EXT0;
         return ST_HEADER;
      end
      return end_of_header();
   endfunction

   function automatic logic [1:0] end_of_basic();
      if (cur_fmt == FMT_CONTINUE) begin
         if (msg_fresh) begin
            hdr_step = AT_BASIC;
            return ST_ERROR;
         end
         return end_of_fields();
      end
      hdr_step = AT_TS0;
      return ST_HEADER;
   endfunction

   function automatic rsp_type decode_byte(input logic [7:0] b);
      rsp_type        r;
      fill_type       next_fill;
      chunk_size_type limit;
      r        = '0;
      r.status = ST_HEADER;
      msg_done = 1'b0;
      case (hdr_step)
         AT_ID_LO: begin
            if (wide_csid) begin
               cur_csid = {9'd0, b};
               hdr_step = AT_ID_HI;
            end else begin
               cur_csid = {9'd0, b} + ID_OFFSET;
               r.status = end_of_basic();
            end
         end
         AT_ID_HI: begin
            cur_csid = {9'd0, cur_csid[7:0]} + {1'b0, b, 8'd0} + ID_OFFSET;
            r.status = end_of_basic();
         end
         AT_TS0: begin
            cur_ts   = {8'd0, b, 16'd0};
            hdr_step = AT_TS1;
         end
         AT_TS1: begin
            cur_ts[15:8] = b;
            hdr_step     = AT_TS2;
         end
         AT_TS2: begin
            cur_ts[7:0] = b;
            ts_extended = (cur_ts == TS_EXTENDED);
            if (cur_fmt == FMT_TS_ONLY) r.status = end_of_fields();
            else hdr_step = AT_LEN0;
         end
         AT_LEN0: begin
            cur_len  = {b, 16'd0};
            hdr_step = AT_LEN1;
         end
         AT_LEN1: begin
            cur_len[15:8] = b;
            hdr_step      = AT_LEN2;
         end
         AT_LEN2: begin
            cur_len[7:0] = b;
            hdr_step     = AT_TYPE;
         end
         AT_TYPE: begin
            cur_type = b;
            if (cur_fmt == FMT_NO_SID) r.status = end_of_fields();
            else hdr_step = AT_SID0;
         end
         AT_SID0: begin
            cur_msid = {24'd0, b};
            hdr_step = AT_SID1;
         end
         AT_SID1: begin
            cur_msid[15:8] = b;
            hdr_step       = AT_SID2;
         end
         AT_SID2: begin
            cur_msid[23:16] = b;
            hdr_step        = AT_SID3;
         end
         AT_SID3: begin
            cur_msid[31:24] = b;
            r.status        = end_of_fields();
         end
         AT_EXT0: begin
            cur_ts   = {b, 24'd0};
            hdr_step = AT_EXT1;
         end
         AT_EXT1: begin
            cur_ts[23:16] = b;
            hdr_step      = AT_EXT2;
         end
         AT_EXT2: begin
            cur_ts[15:8] = b;
            hdr_step     = AT_EXT3;
         end
         AT_EXT3: begin
            cur_ts[7:0] = b;
            r.status    = end_of_header();
         end
         AT_DATA: begin
            limit          = (chunk_size == '0) ? chunk_size_type'(1) : chunk_size;
            next_fill      = chunk_fill + 1'b1;
            r.payload_byte = b;
            payload_seen   = payload_seen + 1'b1;
            if (next_fill == limit || &next_fill) begin
               r.chunk_end = 1'b1;
               chunk_fill  = '0;
               hdr_step    = AT_BASIC;
            end else begin
               chunk_fill = next_fill;
            end
            if (payload_seen >= cur_len) begin
               r.status = ST_LAST;
               msg_done = 1'b1;
            end else begin
               r.status = ST_PAYLOAD;
            end
         end
         default: begin
            cur_fmt  = b[7:6];
            cur_csid = {11'd0, b[5:0]};
            if (b[5:0] == ID_TWO_BYTE || b[5:0] == ID_THREE_BYTE) begin
               wide_csid = (b[5:0] == ID_THREE_BYTE);
               hdr_step  = AT_ID_LO;
            end else begin
               r.status = end_of_basic();
            end
         end
      endcase
      r.chunk_fmt     = cur_fmt;
      r.chunk_stream  = cur_csid;
      r.msg_timestamp = cur_ts;
      r.msg_length    = cur_len;
      r.msg_type      = cur_type;
      r.msg_stream    = cur_msid;
      if (msg_done) clear_msg_context();
      return r;
   endfunction

   // one chunk header for the current context; for a fresh message it may be a format 3 error case
   function automatic void build_header(ref logic [7:0] hdr[$], input int max_len);
      logic [1:0]  fmt;
      logic [23:0] ts;
      logic [23:0] len;
      logic [31:0] msid;
      logic        ext_next;
      int          r;
      hdr.delete();
      r = $urandom_range(99);
      if (msg_fresh)
         fmt = (r < 70) ? FMT_FULL : (r < 82) ? FMT_NO_SID : (r < 94) ? FMT_TS_ONLY : FMT_CONTINUE;
      else
         fmt = (r < 75) ? FMT_CONTINUE : (r < 85) ? FMT_FULL : (r < 93) ? FMT_NO_SID : FMT_TS_ONLY;
      r = $urandom_range(99);
      if (r < 70) begin
         hdr.push_back({fmt, 6'($urandom_range(63, 2))});
      end else if (r < 85) begin
         hdr.push_back({fmt, ID_TWO_BYTE});
         hdr.push_back(8'($urandom));
      end else begin
         hdr.push_back({fmt, ID_THREE_BYTE});
         hdr.push_back(8'($urandom));
         hdr.push_back(8'($urandom));
      end
      if (fmt == FMT_CONTINUE) begin
         ext_next = !msg_fresh && ts_extended;
      end else begin
         ts       = ($urandom_range(99) < 20) ? TS_EXTENDED[23:0] : 24'($urandom);
         ext_next = (ts == TS_EXTENDED[23:0]);
         hdr.push_back(ts[23:16]);
         hdr.push_back(ts[15:8]);
         hdr.push_back(ts[7:0]);
         if (fmt != FMT_TS_ONLY) begin
            r = $urandom_range(99);
            if (r < 8) len = 24'd0;
            else if (r < 10 && chunk_size <= 16) len = 24'hFF_FFFF;
            else len = 24'($urandom_range(max_len, 1));
            hdr.push_back(len[23:16]);
            hdr.push_back(len[15:8]);
            hdr.push_back(len[7:0]);
            hdr.push_back(8'($urandom));
            if (fmt == FMT_FULL) begin
               msid = $urandom;
               hdr.push_back(msid[7:0]);
               hdr.push_back(msid[15:8]);
               hdr.push_back(msid[23:16]);
               hdr.push_back(msid[31:24]);
            end
         end
      end
      if (ext_next) repeat (4) hdr.push_back(8'($urandom));
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      expected_beats.push_back(decode_byte(b));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_chunk_size(input chunk_size_type value);
      wait_drained();
      csr_valid      <= 1'b1;
      csr_chunk_size <= value;
      do @(posedge clock); while (!csr_ready);
      chunk_size = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic stream_messages(input int n_items, input int max_len);
      logic [7:0] hdr[$];
      int         sent;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 4 || hdr_step != AT_BASIC) begin
            send_byte(8'($urandom));
            sent++;
         end else begin
            build_header(hdr, max_len);
            foreach (hdr[i]) send_byte(hdr[i]);
            sent += hdr.size();
         end
      end
   endtask

   task automatic test_fresh_continuation_error();
      send_byte(8'hFF);
   endtask

   task automatic test_zero_length_extended();
      logic [7:0] seq[$];
      seq = '{8'h80, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   task automatic test_wide_id_payload();
      logic [7:0] seq[$];
      seq = '{8'h41, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00,
              8'h00, 8'hFF};
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   task automatic test_chunk_size_extremes();
      chunk_size_type sizes[$];
      sizes = '{17'd0, 17'd1, 17'h1_0000, 17'h1_FFFF};
      foreach (sizes[i]) begin
         write_chunk_size(sizes[i]);
         stream_messages(40, 12);
      end
   endtask

   task automatic test_random_stream(input int send_pct, input int recv_pct,
                                     input chunk_size_type size, input int n_items);
      write_chunk_size(size);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stream_messages(n_items, (size < 64) ? 4 * int'(size) + 4 : 300);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      stream_messages(40, 20);
   endtask

   // receiver: random stall, or a long hold when one is requested
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
   endtask

   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_status, rsp_payload_byte, rsp_chunk_fmt, rsp_chunk_stream,
                 rsp_msg_timestamp, rsp_msg_length, rsp_msg_type, rsp_msg_stream,
                 rsp_chunk_end};
         if (expected_beats.size() == 0) begin
            flag_mismatch("unexpected beat status", 32'(seen.status), 32'd0);
         end else begin
            want = expected_beats.pop_front();
            if (seen.status !== want.status)
               flag_mismatch("status", 32'(seen.status), 32'(want.status));
            if (seen.payload_byte !== want.payload_byte)
               flag_mismatch("payload_byte", 32'(seen.payload_byte),
                             32'(want.payload_byte));
            if (seen.chunk_fmt !== want.chunk_fmt)
               flag_mismatch("chunk_fmt", 32'(seen.chunk_fmt), 32'(want.chunk_fmt));
            if (seen.chunk_stream !== want.chunk_stream)
               flag_mismatch("chunk_stream", 32'(seen.chunk_stream),
                             32'(want.chunk_stream));
            if (seen.msg_timestamp !== want.msg_timestamp)
               flag_mismatch("msg_timestamp", seen.msg_timestamp, want.msg_timestamp);
            if (seen.msg_length !== want.msg_length)
               flag_mismatch("msg_length", 32'(seen.msg_length), 32'(want.msg_length));
            if (seen.msg_type !== want.msg_type)
               flag_mismatch("msg_type", 32'(seen.msg_type), 32'(want.msg_type));
            if (seen.msg_stream !== want.msg_stream)
               flag_mismatch("msg_stream", seen.msg_stream, want.msg_stream);
            if (seen.chunk_end !== want.chunk_end)
               flag_mismatch("chunk_end", 32'(seen.chunk_end), 32'(want.chunk_end));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      chunk_size = CHUNK_SIZE_RESET;
      clear_msg_context();
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_fresh_continuation_error();
      test_zero_length_extended();
      test_wide_id_payload();
      test_chunk_size_extremes();
      test_random_stream(32, 76, 17'd5, 420);
      test_random_stream(76, 32, 17'd13, 420);
      write_chunk_size(17'd7);
      test_backpressure();
      test_random_stream(0, 0, CHUNK_SIZE_RESET, 420);
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
